>>> rtl/lfpd_pkg.sv
// lfpd_pkg: shared types and constants of the line follower drive
// depends on nothing; imported by every module of the block
package lfpd_pkg;

    localparam int SENSORS           = 5;
    localparam int SAMPLE_BITS_DEF   = 10;
    localparam int FRACTION_BITS_DEF = 12;
    localparam int CFG_IDX_W         = 3;
    localparam int CFG_DATA_W        = 24;
    localparam int GAIN_W            = 24;
    localparam int DRIVE_W           = 8;
    localparam int SETPOINT_W        = 15;
    localparam int LEVEL_W           = 10;
    localparam int OUT_ERR_W         = 16;
    localparam int OUT_W             = 40;
    localparam int SUM_W             = 40;
    localparam int SUM_SPLIT         = 20;
    localparam int ACC_W             = 68;
    localparam int MUL_STEPS         = 4;
    localparam int PEAK_RESET        = 500;
    localparam int FLOOR_RESET       = 90;
    localparam int REVERSE_LIMIT     = 250;
    localparam int LOST_ERROR        = 3;

    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_DRIVE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CEILING    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SETPOINT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_LEVEL = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_LEVEL  = 3'd7;

    // commands from the controller to the datapath
    typedef struct packed {
        logic       capture;
        logic       track;
        logic       div_load;
        logic       div_step;
        logic       div_last;
        logic [2:0] sens;
        logic       err;
        logic       mul;
        logic [2:0] mstep;
        logic       drv_left;
        logic       drv_right;
        logic       finish;
    } t_cmd;

endpackage

>>> rtl/line_follower_pid_drive.sv
// line_follower_pid_drive: top level of the five sensor pid line follower drive
// depends on lfpd_pkg, lfpd_ctrl and lfpd_dp
//
// channel   dir  handshake                        payload
// s_axis    in   s_axis_tvalid / s_axis_tready    five samples, one tick
// m_axis    out  m_axis_tvalid / m_axis_tready    wheel drives and error
// cfg       in   i_cfg_we                         index i_cfg_idx, data i_cfg_data
//
// a tick is paced by the shared restoring divider, which gives one quotient bit
// per cycle for each sensor
// a new request is taken while the previous result still waits in the output
// register; the tick then holds in its last state until the result is taken
// reset is synchronous and active low and restores gains, levels and state
module line_follower_pid_drive #(
    parameter int SAMPLE_BITS   = lfpd_pkg::SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS = lfpd_pkg::FRACTION_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // left_outer, left_inner, middle, right_inner, right_outer samples
    input  logic [((lfpd_pkg::SENSORS*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // left_magnitude, left_reverse, right_magnitude, right_reverse, position_error
    output logic [lfpd_pkg::OUT_W-1:0]          m_axis_tdata,
    input  logic                                i_cfg_we,
    input  logic [lfpd_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [lfpd_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import lfpd_pkg::*;

    t_cmd cmd;

    lfpd_ctrl #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd)
    );

    lfpd_dp #(
        .SAMPLE_BITS  (SAMPLE_BITS),
        .FRACTION_BITS(FRACTION_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_samples  (s_axis_tdata[SENSORS*SAMPLE_BITS-1:0]),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_result   (m_axis_tdata)
    );

endmodule

>>> rtl/lfpd_ctrl.sv
// lfpd_ctrl: sequencer of one control tick and the result handshake
// depends on lfpd_pkg; drives the command struct of lfpd_dp
module lfpd_ctrl #(
    parameter int FRACTION_BITS = lfpd_pkg::FRACTION_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output lfpd_pkg::t_cmd  o_cmd
);
    import lfpd_pkg::*;

    localparam int BIT_W = $clog2(FRACTION_BITS + 1);
    localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(FRACTION_BITS);
    localparam logic [2:0] SENS_LAST = 3'(SENSORS - 1);
    localparam logic [2:0] MSTEP_LAST = 3'(MUL_STEPS);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_TRACK = 9'b000000010,
        S_LOAD  = 9'b000000100,
        S_STEP  = 9'b000001000,
        S_ERR   = 9'b000010000,
        S_MUL   = 9'b000100000,
        S_DRVL  = 9'b001000000,
        S_DRVR  = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    t_state           r_state, n_state;
    logic [2:0]       r_sens, n_sens;
    logic [BIT_W-1:0] r_bit, n_bit;
    logic [2:0]       r_mstep, n_mstep;
    logic             r_ovalid, n_ovalid;
    logic             accept, finish;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign accept      = i_in_valid && o_in_ready;
    assign finish      = (r_state == S_DONE) && (!r_ovalid || i_out_ready);

    always_comb begin
        n_state  = r_state;
        n_sens   = r_sens;
        n_bit    = r_bit;
        n_mstep  = r_mstep;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_TRACK;
                end
            end
            S_TRACK: begin
                n_state = S_LOAD;
                n_sens  = '0;
            end
            S_LOAD: begin
                n_state = S_STEP;
                n_bit   = '0;
            end
            S_STEP: begin
                n_bit = r_bit + 1'b1;
                if (r_bit == BIT_LAST) begin
                    if (r_sens == SENS_LAST) begin
                        n_state = S_ERR;
                    end else begin
                        n_sens  = r_sens + 1'b1;
                        n_state = S_LOAD;
                    end
                end
            end
            S_ERR: begin
                n_state = S_MUL;
                n_mstep = '0;
            end
            S_MUL: begin
                n_mstep = r_mstep + 1'b1;
                if (r_mstep == MSTEP_LAST) begin
                    n_state = S_DRVL;
                end
            end
            S_DRVL: n_state = S_DRVR;
            S_DRVR: n_state = S_DONE;
            S_DONE: begin
                if (finish) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_ovalid = r_ovalid;
        if (finish) begin
            n_ovalid = 1'b1;
        end else if (i_out_ready) begin
            n_ovalid = 1'b0;
        end
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.capture   = accept;
        o_cmd.track     = (r_state == S_TRACK);
        o_cmd.div_load  = (r_state == S_LOAD);
        o_cmd.div_step  = (r_state == S_STEP);
        o_cmd.div_last  = (r_state == S_STEP) && (r_bit == BIT_LAST);
        o_cmd.sens      = r_sens;
        o_cmd.err       = (r_state == S_ERR);
        o_cmd.mul       = (r_state == S_MUL);
        o_cmd.mstep     = r_mstep;
        o_cmd.drv_left  = (r_state == S_DRVL);
        o_cmd.drv_right = (r_state == S_DRVR);
        o_cmd.finish    = finish;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_sens   <= '0;
            r_bit    <= '0;
            r_mstep  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_sens   <= n_sens;
            r_bit    <= n_bit;
            r_mstep  <= n_mstep;
            r_ovalid <= n_ovalid;
        end
    end

    a_finish_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |=> r_ovalid) else $error("result not shown after finish");
    a_accept_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state == S_TRACK) else $error("accepted request not tracked");
    a_sens_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sens <= SENS_LAST) else $error("sensor index out of range");
    a_div_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.div_last && r_sens == SENS_LAST) |=> r_state == S_ERR)
        else $error("division sweep did not end");

endmodule

>>> rtl/lfpd_dp.sv
// lfpd_dp: sensor tracking, shared divider, error, shared multiplier and drives
// depends on lfpd_pkg; sequenced by lfpd_ctrl
module lfpd_dp #(
    parameter int SAMPLE_BITS   = lfpd_pkg::SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS = lfpd_pkg::FRACTION_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  lfpd_pkg::t_cmd                         i_cmd,
    input  logic [lfpd_pkg::SENSORS*SAMPLE_BITS-1:0] i_samples,
    input  logic                                   i_cfg_we,
    input  logic [lfpd_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [lfpd_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    output logic [lfpd_pkg::OUT_W-1:0]             o_result
);
    import lfpd_pkg::*;

    localparam int SB     = SAMPLE_BITS;
    localparam int F      = FRACTION_BITS;
    localparam int N_W    = F + 1;
    localparam int ERR_W  = (F + 5 > 17) ? F + 5 : 17;
    localparam int DIFF_W = ERR_W + 1;
    localparam int MB     = (DIFF_W > SUM_SPLIT + 1) ? DIFF_W : SUM_SPLIT + 1;
    localparam int MA     = GAIN_W + 1;
    localparam int PROD_W = MA + MB;
    localparam int SH     = 2 * F;

    // configuration registers
    logic [GAIN_W-1:0]            r_kp, r_ki, r_kd;
    logic [DRIVE_W-1:0]           r_base, r_ceil;
    logic signed [SETPOINT_W-1:0] r_setpoint;
    logic [LEVEL_W-1:0]           r_high, r_low;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp       <= GAIN_W'(614400);
            r_ki       <= GAIN_W'(4);
            r_kd       <= GAIN_W'(4096000);
            r_base     <= DRIVE_W'(230);
            r_ceil     <= DRIVE_W'(250);
            r_setpoint <= '0;
            r_high     <= LEVEL_W'(700);
            r_low      <= LEVEL_W'(200);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_PROP_GAIN:  r_kp       <= i_cfg_data;
                REG_INTEG_GAIN: r_ki       <= i_cfg_data;
                REG_DERIV_GAIN: r_kd       <= i_cfg_data;
                REG_BASE_DRIVE: r_base     <= i_cfg_data[DRIVE_W-1:0];
                REG_CEILING:    r_ceil     <= i_cfg_data[DRIVE_W-1:0];
                REG_SETPOINT:   r_setpoint <= i_cfg_data[SETPOINT_W-1:0];
                REG_HIGH_LEVEL: r_high     <= i_cfg_data[LEVEL_W-1:0];
                REG_LOW_LEVEL:  r_low      <= i_cfg_data[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    // samples and per sensor range tracking
    logic [SB-1:0]  r_samp  [SENSORS];
    logic [SB-1:0]  r_peak  [SENSORS];
    logic [SB-1:0]  r_floor [SENSORS];
    logic [N_W-1:0] r_norm  [SENSORS];

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            for (int i = 0; i < SENSORS; i++) begin
                r_samp[i] <= i_samples[i*SB +: SB];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SENSORS; i++) begin
                r_peak[i]  <= SB'(PEAK_RESET);
                r_floor[i] <= SB'(FLOOR_RESET);
            end
        end else if (i_cmd.track) begin
            for (int i = 0; i < SENSORS; i++) begin
                if (r_samp[i] >= r_peak[i]) begin
                    r_peak[i] <= r_samp[i];
                end
                if (r_samp[i] <= r_floor[i]) begin
                    r_floor[i] <= r_samp[i];
                end
            end
        end
    end

    // restoring divider, one quotient bit per cycle
    logic [SB:0]    r_rem;
    logic [SB-1:0]  r_den;
    logic           r_den_zero;
    logic [N_W-1:0] r_quo;
    logic [SB:0]    rem_sub;
    logic           quo_bit;
    logic [2:0]     sidx;

    assign sidx    = i_cmd.sens;
    assign quo_bit = (r_rem >= {1'b0, r_den}) && !r_den_zero;
    assign rem_sub = quo_bit ? r_rem - {1'b0, r_den} : r_rem;

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_rem      <= {1'b0, r_samp[sidx] - r_floor[sidx]};
            r_den      <= r_peak[sidx] - r_floor[sidx];
            r_den_zero <= (r_peak[sidx] == r_floor[sidx]);
            r_quo      <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= {rem_sub[SB-1:0], 1'b0};
            r_quo <= {r_quo[N_W-2:0], quo_bit};
            if (i_cmd.div_last) begin
                r_norm[sidx] <= {r_quo[N_W-2:0], quo_bit};
            end
        end
    end

    // position error
    logic [SENSORS-1:0]        above, below;
    logic                      all_low, left_edge, right_edge;
    logic signed [ERR_W-1:0]   n_ext [SENSORS];
    logic signed [ERR_W-1:0]   pos, err_calc, lost;
    logic signed [ERR_W-1:0]   r_err, r_last;
    logic signed [DIFF_W-1:0]  r_diff;
    logic signed [SUM_W-1:0]   r_sum;

    always_comb begin
        for (int i = 0; i < SENSORS; i++) begin
            above[i] = {{(32-SB){1'b0}}, r_samp[i]} > {{(32-LEVEL_W){1'b0}}, r_high};
            below[i] = {{(32-SB){1'b0}}, r_samp[i]} < {{(32-LEVEL_W){1'b0}}, r_low};
            n_ext[i] = ERR_W'(r_norm[i]);
        end
        all_low    = &below;
        left_edge  = above[0] && above[1] && above[2] && above[3] && below[4];
        right_edge = below[0] && above[1] && above[2] && above[3] && above[4];
        pos = '0;
        if (!right_edge) begin
            pos = pos - (n_ext[0] <<< 1) - n_ext[1];
        end
        if (!left_edge) begin
            pos = pos + n_ext[3] + (n_ext[4] <<< 1);
        end
        lost = ERR_W'(LOST_ERROR) <<< F;
        if (all_low) begin
            err_calc = r_last[ERR_W-1] ? -lost : lost;
        end else begin
            err_calc = pos - ERR_W'(r_setpoint);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.err) begin
            r_err  <= err_calc;
            r_diff <= DIFF_W'(err_calc) - DIFF_W'(r_last);
        end
    end

    // shared multiplier: kp*e, kd*de, ki*sum low part, ki*sum high part
    logic signed [MA-1:0]     mul_a;
    logic signed [MB-1:0]     mul_b;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_prod_hi;
    logic signed [ACC_W-1:0]  r_acc, prod_ext;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (i_cmd.mstep)
            3'd0: begin
                mul_a = signed'({1'b0, r_kp});
                mul_b = MB'(r_err);
            end
            3'd1: begin
                mul_a = signed'({1'b0, r_kd});
                mul_b = MB'(r_diff);
            end
            3'd2: begin
                mul_a = signed'({1'b0, r_ki});
                mul_b = signed'(MB'({1'b0, r_sum[SUM_SPLIT-1:0]}));
            end
            3'd3: begin
                mul_a = signed'({1'b0, r_ki});
                mul_b = MB'(signed'(r_sum[SUM_W-1:SUM_SPLIT]));
            end
            default: ;
        endcase
        prod_ext = ACC_W'(r_prod);
        if (r_prod_hi) begin
            prod_ext = prod_ext <<< SUM_SPLIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod    <= mul_a * mul_b;
            r_prod_hi <= (i_cmd.mstep == 3'd3);
            if (i_cmd.mstep == 3'd0) begin
                r_acc <= '0;
            end else begin
                r_acc <= r_acc + prod_ext;
            end
        end
    end

    // drive clamp, left then right
    logic signed [ACC_W-1:0] base_sh, ceil_sh, lim_sh, drive, drive_abs;
    logic [DRIVE_W-1:0]      mag;
    logic                    rev;
    logic [DRIVE_W-1:0]      r_lmag, r_rmag;
    logic                    r_lrev, r_rrev;

    always_comb begin
        base_sh = ACC_W'(r_base) <<< SH;
        ceil_sh = ACC_W'(r_ceil) <<< SH;
        lim_sh  = -(ACC_W'(REVERSE_LIMIT) <<< SH);
        drive   = i_cmd.drv_right ? base_sh - r_acc : base_sh + r_acc;
        drive_abs = drive[ACC_W-1] ? -drive : drive;
        if (drive > ceil_sh) begin
            mag = r_ceil;
            rev = 1'b0;
        end else if (drive < lim_sh) begin
            mag = DRIVE_W'(REVERSE_LIMIT);
            rev = 1'b1;
        end else begin
            mag = drive_abs[SH +: DRIVE_W];
            rev = drive[ACC_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.drv_left) begin
            r_lmag <= mag;
            r_lrev <= rev;
        end
        if (i_cmd.drv_right) begin
            r_rmag <= mag;
            r_rrev <= rev;
        end
    end

    // commit of the tick: result register, last error and saturating integral
    logic signed [SUM_W:0] sum_next;
    logic [OUT_W-1:0]      r_result;

    assign sum_next = (SUM_W+1)'(r_sum) + (SUM_W+1)'(r_err);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= '0;
            r_sum  <= '0;
        end else if (i_cmd.finish) begin
            r_last <= r_err;
            if (sum_next[SUM_W] != sum_next[SUM_W-1]) begin
                r_sum <= {sum_next[SUM_W], {(SUM_W-1){~sum_next[SUM_W]}}};
            end else begin
                r_sum <= sum_next[SUM_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_result <= OUT_W'({r_err[OUT_ERR_W-1:0], r_rrev, r_rmag, r_lrev, r_lmag});
        end
    end

    assign o_result = r_result;

endmodule

>>> test/line_follower_pid_drive_checker.sv
`timescale 1ns / 100ps
// line_follower_pid_drive_checker: watches the sample, drive and cfg ports,
// predicts each tick's drives and error, and counts mismatches; depends on lfpd_pkg
module line_follower_pid_drive_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_valid,
    input  logic                             i_s_ready,
    input  logic [55:0]                      i_s_data,
    input  logic                             i_m_valid,
    input  logic                             i_m_ready,
    input  logic [lfpd_pkg::OUT_W-1:0]       i_m_data,
    input  logic                             i_cfg_we,
    input  logic [lfpd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [lfpd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output int                               o_fail_count,
    output int                               o_pending
);
    import lfpd_pkg::*;

    typedef logic signed [127:0] t_wide;

    // packed from the msb down, so it lines up with tdata[33:0]
    typedef struct packed {
        logic [15:0] err;
        logic        right_rev;
        logic [7:0]  right_mag;
        logic        left_rev;
        logic [7:0]  left_mag;
    } t_drive_result;

    localparam longint SUM_HI = 64'sd549755813887;
    localparam longint SUM_LO = -64'sd549755813888;

    longint prop_gain, integ_gain, deriv_gain, base_drive, ceiling, setpoint;
    longint high_level, low_level;
    longint peak [SENSORS];
    longint floor_lvl [SENSORS];
    longint last_err, err_sum;

    t_drive_result expected_drives [$];
    int fails;

    function automatic logic [8:0] wheel_drive(t_wide drv);
        t_wide one, hi, lo, mag;
        one = t_wide'(1) <<< 24;
        hi = ceiling;
        hi = hi * one;
        lo = -250 * one;
        if (drv > hi) drv = hi;
        if (drv < lo) drv = lo;
        mag = (drv < 0) ? -drv : drv;
        mag = mag / one;
        return {drv < 0, mag[7:0]};
    endfunction

    function automatic t_drive_result track_tick(logic [49:0] samples);
        t_drive_result r;
        longint s, den, err, pos;
        longint n [SENSORS];
        bit above [SENSORS];
        bit below [SENSORS];
        bit all_low, left_edge, right_edge;
        t_wide w_err, w_diff, w_sum, ti, corr, base, g;
        logic [8:0] wl, wr;
        all_low = 1;
        for (int i = 0; i < SENSORS; i++) begin
            s = samples[i*10 +: 10];
            if (s >= peak[i]) peak[i] = s;
            if (s <= floor_lvl[i]) floor_lvl[i] = s;
            den = (peak[i] > floor_lvl[i]) ? peak[i] - floor_lvl[i] : 0;
            n[i] = (den == 0) ? 0 : ((s - floor_lvl[i]) << 12) / den;
            above[i] = s > high_level;
            below[i] = s < low_level;
            if (!below[i]) all_low = 0;
        end
        left_edge = above[0] && above[1] && above[2] && above[3] && below[4];
        right_edge = below[0] && above[1] && above[2] && above[3] && above[4];
        if (all_low) begin
            // line lost: steer hard toward the side it was last seen
            err = (last_err < 0) ? -(3 * 4096) : 3 * 4096;
        end else begin
            pos = 0;
            if (!right_edge) pos += -2 * n[0] - n[1];
            if (!left_edge) pos += n[3] + 2 * n[4];
            err = pos - setpoint;
        end
        w_err = err;
        w_diff = err - last_err;
        w_sum = err_sum;
        g = integ_gain;
        ti = g * w_sum;
        if (ti > (t_wide'(1) <<< 60)) ti = t_wide'(1) <<< 60;
        if (ti < -(t_wide'(1) <<< 60)) ti = -(t_wide'(1) <<< 60);
        g = prop_gain;
        corr = g * w_err;
        g = deriv_gain;
        corr = corr + g * w_diff + ti;
        base = base_drive;
        base = base <<< 24;
        wl = wheel_drive(base + corr);
        wr = wheel_drive(base - corr);
        r.left_rev = wl[8];
        r.left_mag = wl[7:0];
        r.right_rev = wr[8];
        r.right_mag = wr[7:0];
        r.err = err[15:0];
        last_err = err;
        err_sum = err_sum + err;
        if (err_sum > SUM_HI) err_sum = SUM_HI;
        if (err_sum < SUM_LO) err_sum = SUM_LO;
        return r;
    endfunction

    task automatic report_miss(string what, longint want, longint got);
        fails++;
        if (fails <= 10)
            $display("%0t mismatch %s: expected %0d, got %0d", $realtime, what, want, got);
    endtask

    always @(posedge i_clk) begin
        t_drive_result want, got;
        if (!i_rst_n) begin
            for (int i = 0; i < SENSORS; i++) begin
                peak[i] = PEAK_RESET;
                floor_lvl[i] = FLOOR_RESET;
            end
            last_err = 0;
            err_sum = 0;
            prop_gain = 614400;
            integ_gain = 4;
            deriv_gain = 4096000;
            base_drive = 230;
            ceiling = 250;
            setpoint = 0;
            high_level = 700;
            low_level = 200;
            expected_drives.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_PROP_GAIN:  prop_gain = i_cfg_data;
                    REG_INTEG_GAIN: integ_gain = i_cfg_data;
                    REG_DERIV_GAIN: deriv_gain = i_cfg_data;
                    REG_BASE_DRIVE: base_drive = i_cfg_data[7:0];
                    REG_CEILING:    ceiling = i_cfg_data[7:0];
                    REG_SETPOINT:   setpoint = longint'($signed(i_cfg_data[14:0]));
                    REG_HIGH_LEVEL: high_level = i_cfg_data[9:0];
                    REG_LOW_LEVEL:  low_level = i_cfg_data[9:0];
                    default: ;
                endcase
            end
            if (i_m_valid && i_m_ready) begin
                got = i_m_data[33:0];
                if (expected_drives.size() == 0) begin
                    report_miss("unexpected result, err field", 0, $signed(got.err));
                end else begin
                    want = expected_drives.pop_front();
                    if (got.left_mag != want.left_mag)
                        report_miss("left_magnitude", want.left_mag, got.left_mag);
                    if (got.left_rev != want.left_rev)
                        report_miss("left_reverse", want.left_rev, got.left_rev);
                    if (got.right_mag != want.right_mag)
                        report_miss("right_magnitude", want.right_mag, got.right_mag);
                    if (got.right_rev != want.right_rev)
                        report_miss("right_reverse", want.right_rev, got.right_rev);
                    if (got.err != want.err)
                        report_miss("position_error", $signed(want.err), $signed(got.err));
                end
            end
            if (i_s_valid && i_s_ready)
                expected_drives.push_back(track_tick(i_s_data[49:0]));
        end
        o_fail_count <= fails;
        o_pending <= expected_drives.size();
    end

endmodule

>>> test/line_follower_pid_drive_test.sv
`timescale 1ns / 100ps
// line_follower_pid_drive_test: drives sensor ticks and register writes into the
// line follower drive; depends on lfpd_pkg, the block and the checker
module line_follower_pid_drive_test;
    import lfpd_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;

    // tick kinds
    localparam int KIND_NOISE      = 0;
    localparam int KIND_LINE       = 1;
    localparam int KIND_LOST       = 2;
    localparam int KIND_LEFT_EDGE  = 3;
    localparam int KIND_RIGHT_EDGE = 4;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [55:0]           s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_W-1:0]      m_axis_tdata;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int  fail_count, pending, cycles;
    bit  steady;
    int  cur_high, cur_low;

    line_follower_pid_drive uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    line_follower_pid_drive_checker drive_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_valid(s_axis_tvalid), .i_s_ready(s_axis_tready), .i_s_data(s_axis_tdata),
        .i_m_valid(m_axis_tvalid), .i_m_ready(m_axis_tready), .i_m_data(m_axis_tdata),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 40) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("line_follower_pid_drive_test: FAIL");
            $finish;
        end
    end

    // output side back pressure
    always @(posedge i_clk) begin
        if (!i_rst_n || steady) begin
            m_axis_tready <= 1'b1;
        end else if ($urandom_range(0, 99) < 8) begin
            m_axis_tready <= 1'b0;
        end else if (!m_axis_tready &&
                     $urandom_range(0, 99) < 90 - 40 * ($urandom_range(0, 9) == 0)) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    function automatic logic [9:0] above_high();
        return (cur_high >= 1023) ? 10'd1023 : 10'($urandom_range(cur_high + 1, 1023));
    endfunction

    function automatic logic [9:0] below_low();
        return (cur_low == 0) ? 10'd0 : 10'($urandom_range(0, cur_low - 1));
    endfunction

    function automatic logic [49:0] make_tick(int kind);
        logic [49:0] d;
        int center, offset;
        d = 50'({$urandom, $urandom});
        for (int i = 0; i < SENSORS; i++) begin
            case (kind)
                KIND_LINE: begin
                    center = $urandom_range(0, 4);
                    offset = (i > center) ? i - center : center - i;
                    if (offset == 0) d[i*10 +: 10] = 10'($urandom_range(700, 1023));
                    else if (offset == 1) d[i*10 +: 10] = 10'($urandom_range(200, 800));
                    else d[i*10 +: 10] = 10'($urandom_range(0, 250));
                end
                KIND_LOST: d[i*10 +: 10] = below_low();
                KIND_LEFT_EDGE: d[i*10 +: 10] = (i == 4) ? below_low() : above_high();
                KIND_RIGHT_EDGE: d[i*10 +: 10] = (i == 0) ? below_low() : above_high();
                default: ;
            endcase
        end
        return d;
    endfunction

    function automatic int pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return KIND_NOISE;
        if (r < 70) return KIND_LINE;
        if (r < 80) return KIND_LOST;
        if (r < 90) return KIND_LEFT_EDGE;
        return KIND_RIGHT_EDGE;
    endfunction

    task automatic send_tick(input logic [49:0] d);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'd0, d};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic send_random(input int count);
        for (int k = 0; k < count; k++) begin
            if (k % 30 == 0) steady = ($urandom_range(0, 3) == 0);
            send_tick(make_tick(pick_kind()));
        end
        steady = 0;
    endtask

    // lets every pending result out, then idles past the tick latency
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input int value);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= CFG_DATA_W'(value);
        @(posedge i_clk);
        if (idx == REG_HIGH_LEVEL) cur_high = value;
        if (idx == REG_LOW_LEVEL) cur_low = value;
    endtask

    task automatic set_regs(input int kp, input int ki, input int kd, input int base,
                            input int ceil, input int sp, input int hi, input int lo);
        reg_write(REG_PROP_GAIN, kp);
        reg_write(REG_INTEG_GAIN, ki);
        reg_write(REG_DERIV_GAIN, kd);
        reg_write(REG_BASE_DRIVE, base);
        reg_write(REG_CEILING, ceil);
        reg_write(REG_SETPOINT, sp & 32'h7fff);
        reg_write(REG_HIGH_LEVEL, hi);
        reg_write(REG_LOW_LEVEL, lo);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        steady = 0;
        cur_high = 700;
        cur_low = 200;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed ticks at reset settings
        send_tick({5{10'd0}});
        send_tick({5{10'd1023}});
        send_tick(make_tick(KIND_LOST));
        for (int c = 0; c < SENSORS; c++) begin
            logic [49:0] d;
            d = {5{10'd50}};
            d[c*10 +: 10] = 10'd1000;
            send_tick(d);
        end
        send_tick(make_tick(KIND_LEFT_EDGE));
        send_tick(make_tick(KIND_RIGHT_EDGE));
        // line far left drives the error negative, then it is lost
        send_tick({10'd0, 10'd0, 10'd0, 10'd600, 10'd1023});
        send_tick(make_tick(KIND_LOST));
        send_tick({10'd1023, 10'd600, 10'd0, 10'd0, 10'd0});
        send_tick(make_tick(KIND_LOST));
        send_random(90);
        wait_idle();

        // gains and base at top, levels crossed so both edge patterns can hold
        set_regs(16777215, 16777215, 16777215, 255, 0, -12288, 100, 900);
        send_tick({10'd50, 10'd950, 10'd950, 10'd950, 10'd950});
        send_tick({10'd950, 10'd950, 10'd950, 10'd950, 10'd50});
        send_tick({10'd500, 10'd950, 10'd950, 10'd950, 10'd500});
        send_random(55);
        wait_idle();

        set_regs(0, 0, 0, 0, 255, 12288, 1023, 0);
        send_random(50);
        wait_idle();

        for (int p = 0; p < 4; p++) begin
            set_regs($urandom_range(0, 2000000), $urandom_range(0, 400),
                     $urandom_range(0, 8000000), $urandom_range(0, 255),
                     $urandom_range(0, 255), $urandom_range(0, 24576) - 12288,
                     $urandom_range(400, 1000), $urandom_range(0, 400));
            send_random(50);
            wait_idle();
        end

        if (fail_count == 0) begin
            $display("line_follower_pid_drive_test: PASS");
        end else begin
            $display("line_follower_pid_drive_test: FAIL");
        end
        $finish;
    end

endmodule
